/* hw/rtl/cod_pkg.sv */
package cod_pkg;

    localparam int MAX_OBSTACLES = 256;
    localparam int ADDR_W        = $clog2(MAX_OBSTACLES);
    localparam int CNT_W         = $clog2(MAX_OBSTACLES + 1);

    localparam int CMD_W      = 2;
    localparam int POS_W      = 16;
    localparam int ENTRY_W    = 2 * POS_W;
    localparam int RADIUS_W   = 12;
    localparam int MAXD_W     = 13;
    localparam int DIST_W     = 16;
    localparam int INTEN_W    = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    localparam int DIFF_W     = POS_W + 1;
    localparam int SQ1_W      = 2 * POS_W;
    localparam int SQ_W       = SQ1_W + 1;
    localparam int ROOT_W     = (SQ_W + 1) / 2;
    localparam int VAL_W      = 2 * ROOT_W;
    localparam int ROOT_STEPS = ROOT_W;
    localparam int FRAC_W     = INTEN_W;
    localparam int STEP_W     = $clog2(ROOT_STEPS + 1);
    localparam int UNIT_W     = ROOT_W + 3;
    localparam int DEN_W      = MAXD_W + 1;
    localparam int CLAMP_W    = ROOT_W + 2;

    localparam int FAR_DISTANCE = 25600;

    typedef enum logic [CMD_W-1:0] {
        CMD_CLEAR    = 2'd0,
        CMD_LOAD     = 2'd1,
        CMD_QUERY    = 2'd2,
        CMD_RESERVED = 2'd3
    } cmd_t;

    localparam logic [CFG_IDX_W-1:0] REG_RADIUS       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_DISTANCE = 2'd1;

    typedef struct packed {
        logic [UNIT_W-1:0] rem;
        logic [UNIT_W-1:0] trial;
    } csub_req_t;

    typedef struct packed {
        logic              ge;
        logic [UNIT_W-1:0] diff;
    } csub_rsp_t;

endpackage

/* hw/rtl/cod_in_if.sv */
interface cod_in_if;
    logic                              valid;
    logic                              ready;
    logic [cod_pkg::CMD_W-1:0]         cmd;
    logic signed [cod_pkg::POS_W-1:0]  pos_x;
    logic signed [cod_pkg::POS_W-1:0]  pos_y;

    modport source (output valid, output cmd, output pos_x, output pos_y, input ready);
    modport sink (input valid, input cmd, input pos_x, input pos_y, output ready);
endinterface

/* hw/rtl/cod_out_if.sv */
interface cod_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [cod_pkg::DIST_W-1:0]  distance;
    logic [cod_pkg::INTEN_W-1:0]        intensity;
    logic                               status;

    modport source (output valid, output distance, output intensity, output status,
                    input ready);
    modport sink (input valid, input distance, input intensity, input status,
                  output ready);
endinterface

/* hw/rtl/cod_cfg_if.sv */
interface cod_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [cod_pkg::CFG_IDX_W-1:0]      index;
    logic [cod_pkg::CFG_DATA_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

/* hw/rtl/cod_ram.sv */
module cod_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* hw/rtl/cod_csub.sv */
module cod_csub (
    input  cod_pkg::csub_req_t req,
    output cod_pkg::csub_rsp_t rsp
);

    // Shared restoring step: compare the partial remainder with the trial value.
    assign rsp.ge   = (req.rem >= req.trial);
    assign rsp.diff = req.rem - req.trial;

endmodule

/* hw/rtl/circle_obstacle_distance_field.sv */
// Circle obstacle distance field.
// Channel "cfg" writes the obstacle radius (index 0) and the distance limit (index 1).
// It is always ready and should only be used while no item is in flight.
// Channel "request" takes one item at a time: clear the obstacle table, load one
// obstacle center, or query a point. Ready is high only while the block is idle.
// Channel "result" returns exactly one item per request: clamped distance and
// intensity for a query, zeros otherwise, and status set when a load found the
// table full.
// A clear, load or reserved item passes through the done state, which moves its
// result into the output register once that register is free, then returns to idle.
// A query with N > 0 stored obstacles reads the table one entry per cycle through
// a squaring pipeline, then one shared compare and subtract unit runs 17 square
// root steps and 16 division steps. A saturated intensity skips the division, and
// a query on an empty table skips both the square root and the division. The block
// returns to idle, ready for the next item, as the result enters the output
// register.
// One finished result may wait in the output register while the next item is
// processed; a stalled receiver only holds the block once a second result is ready.
// Reset empties the table and restores radius 0.5 and max distance 5.0.
module circle_obstacle_distance_field (
    input  logic      clk,
    input  logic      rst_n,
    cod_cfg_if.sink   cfg,
    cod_in_if.sink    request,
    cod_out_if.source result
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_ROOT,
        ST_CLAMP,
        ST_DIVIDE,
        ST_DONE
    } state_t;

    state_t state_reg, state_next;

    logic [cod_pkg::CNT_W-1:0]          count_reg, count_next;
    logic [cod_pkg::RADIUS_W-1:0]       radius_reg, radius_next;
    logic [cod_pkg::MAXD_W-1:0]         maxd_reg, maxd_next;
    logic [cod_pkg::CNT_W-1:0]          idx_reg, idx_next;
    logic                               v1_reg, v1_next;
    logic                               v2_reg, v2_next;
    logic signed [cod_pkg::POS_W-1:0]   px_reg, px_next;
    logic signed [cod_pkg::POS_W-1:0]   py_reg, py_next;
    logic [cod_pkg::SQ1_W-1:0]          sqx_reg, sqx_next;
    logic [cod_pkg::SQ1_W-1:0]          sqy_reg, sqy_next;
    logic [cod_pkg::SQ_W-1:0]           best_reg, best_next;
    logic                               any_reg, any_next;
    logic [cod_pkg::VAL_W-1:0]          val_reg, val_next;
    logic [cod_pkg::UNIT_W-1:0]         rem_reg, rem_next;
    logic [cod_pkg::ROOT_W-1:0]         root_reg, root_next;
    logic [cod_pkg::STEP_W-1:0]         step_reg, step_next;
    logic [cod_pkg::DEN_W-1:0]          den_reg, den_next;
    logic signed [cod_pkg::DIST_W-1:0]  dist_reg, dist_next;
    logic [cod_pkg::INTEN_W-1:0]        quo_reg, quo_next;
    logic                               status_reg, status_next;
    logic                               ovalid_reg, ovalid_next;
    logic signed [cod_pkg::DIST_W-1:0]  odist_reg, odist_next;
    logic [cod_pkg::INTEN_W-1:0]        oint_reg, oint_next;
    logic                               ostat_reg, ostat_next;

    logic                               ram_we;
    logic [cod_pkg::ENTRY_W-1:0]        ram_rdata;
    logic                               issue;
    logic signed [cod_pkg::DIFF_W-1:0]  dx, dy;
    logic signed [2*cod_pkg::DIFF_W-1:0] prod_x, prod_y;
    logic [cod_pkg::SQ_W-1:0]           sum_sq;
    logic signed [cod_pkg::CLAMP_W-1:0] d_raw, d_lo, d_cl, neg_r, mx_s, n_full;
    logic [cod_pkg::DEN_W-1:0]          num;
    cod_pkg::csub_req_t                 unit_req;
    cod_pkg::csub_rsp_t                 unit_rsp;

    cod_ram #(
        .WIDTH(cod_pkg::ENTRY_W),
        .DEPTH(cod_pkg::MAX_OBSTACLES)
    ) u_store (
        .clk  (clk),
        .we   (ram_we),
        .waddr(count_reg[cod_pkg::ADDR_W-1:0]),
        .wdata({request.pos_x, request.pos_y}),
        .raddr(idx_reg[cod_pkg::ADDR_W-1:0]),
        .rdata(ram_rdata)
    );

    cod_csub u_csub (
        .req(unit_req),
        .rsp(unit_rsp)
    );

    assign cfg.ready      = 1'b1;
    assign request.ready  = (state_reg == ST_IDLE);
    assign result.valid   = ovalid_reg;
    assign result.distance  = odist_reg;
    assign result.intensity = oint_reg;
    assign result.status    = ostat_reg;

    assign ram_we = request.valid && request.ready
                    && (cod_pkg::cmd_t'(request.cmd) == cod_pkg::CMD_LOAD)
                    && (count_reg < cod_pkg::CNT_W'(cod_pkg::MAX_OBSTACLES));

    assign issue  = (state_reg == ST_SCAN) && (idx_reg < count_reg);

    assign dx     = {px_reg[cod_pkg::POS_W-1], px_reg}
                    - {ram_rdata[cod_pkg::ENTRY_W-1],
                       ram_rdata[cod_pkg::ENTRY_W-1 -: cod_pkg::POS_W]};
    assign dy     = {py_reg[cod_pkg::POS_W-1], py_reg}
                    - {ram_rdata[cod_pkg::POS_W-1], ram_rdata[cod_pkg::POS_W-1:0]};
    assign prod_x = dx * dx;
    assign prod_y = dy * dy;
    assign sum_sq = {1'b0, sqx_reg} + {1'b0, sqy_reg};

    assign neg_r  = -$signed({{(cod_pkg::CLAMP_W - cod_pkg::RADIUS_W){1'b0}}, radius_reg});
    assign mx_s   = $signed({{(cod_pkg::CLAMP_W - cod_pkg::MAXD_W){1'b0}}, maxd_reg});
    assign d_raw  = any_reg
                    ? $signed({2'b00, root_reg}) + neg_r
                    : cod_pkg::CLAMP_W'(cod_pkg::FAR_DISTANCE);
    assign d_lo   = (d_raw < neg_r) ? neg_r : d_raw;
    assign d_cl   = (d_lo > mx_s) ? mx_s : d_lo;
    assign n_full = d_cl - neg_r;
    assign num    = n_full[cod_pkg::DEN_W-1:0];

    always_comb
    begin
        unit_req.rem   = {rem_reg[cod_pkg::UNIT_W-2:0], 1'b0};
        unit_req.trial = cod_pkg::UNIT_W'(den_reg);
        if (state_reg == ST_ROOT)
        begin
            unit_req.rem   = {rem_reg[cod_pkg::UNIT_W-3:0], val_reg[cod_pkg::VAL_W-1 -: 2]};
            unit_req.trial = cod_pkg::UNIT_W'({root_reg, 2'b01});
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        radius_next = radius_reg;
        maxd_next   = maxd_reg;
        idx_next    = idx_reg;
        v1_next     = issue;
        v2_next     = v1_reg;
        px_next     = px_reg;
        py_next     = py_reg;
        sqx_next    = prod_x[cod_pkg::SQ1_W-1:0];
        sqy_next    = prod_y[cod_pkg::SQ1_W-1:0];
        best_next   = best_reg;
        any_next    = any_reg;
        val_next    = val_reg;
        rem_next    = rem_reg;
        root_next   = root_reg;
        step_next   = step_reg;
        den_next    = den_reg;
        dist_next   = dist_reg;
        quo_next    = quo_reg;
        status_next = status_reg;
        ovalid_next = ovalid_reg && !result.ready;
        odist_next  = odist_reg;
        oint_next   = oint_reg;
        ostat_next  = ostat_reg;

        if (cfg.valid)
        begin
            if (cfg.index == cod_pkg::REG_RADIUS)
            begin
                radius_next = cfg.data[cod_pkg::RADIUS_W-1:0];
            end
            else if (cfg.index == cod_pkg::REG_MAX_DISTANCE)
            begin
                maxd_next = cfg.data[cod_pkg::MAXD_W-1:0];
            end
        end

        if (v2_reg && (!any_reg || (sum_sq < best_reg)))
        begin
            best_next = sum_sq;
            any_next  = 1'b1;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (request.valid)
                begin
                    dist_next   = '0;
                    quo_next    = '0;
                    status_next = 1'b0;
                    state_next  = ST_DONE;
                    unique case (cod_pkg::cmd_t'(request.cmd))
                        cod_pkg::CMD_CLEAR:
                        begin
                            count_next = '0;
                        end
                        cod_pkg::CMD_LOAD:
                        begin
                            if (ram_we)
                            begin
                                count_next = count_reg + 1'b1;
                            end
                            else
                            begin
                                status_next = 1'b1;
                            end
                        end
                        cod_pkg::CMD_QUERY:
                        begin
                            px_next    = request.pos_x;
                            py_next    = request.pos_y;
                            idx_next   = '0;
                            any_next   = 1'b0;
                            state_next = ST_SCAN;
                        end
                        cod_pkg::CMD_RESERVED:
                        begin
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (issue)
                begin
                    idx_next = idx_reg + 1'b1;
                end
                else if (!v1_reg && !v2_reg)
                begin
                    val_next   = cod_pkg::VAL_W'(best_reg);
                    rem_next   = '0;
                    root_next  = '0;
                    step_next  = '0;
                    state_next = any_reg ? ST_ROOT : ST_CLAMP;
                end
            end
            ST_ROOT:
            begin
                rem_next  = unit_rsp.ge ? unit_rsp.diff : unit_req.rem;
                root_next = {root_reg[cod_pkg::ROOT_W-2:0], unit_rsp.ge};
                val_next  = {val_reg[cod_pkg::VAL_W-3:0], 2'b00};
                step_next = step_reg + 1'b1;
                if (step_reg == cod_pkg::STEP_W'(cod_pkg::ROOT_STEPS - 1))
                begin
                    state_next = ST_CLAMP;
                end
            end
            ST_CLAMP:
            begin
                dist_next = d_cl[cod_pkg::DIST_W-1:0];
                den_next  = cod_pkg::DEN_W'(maxd_reg) + cod_pkg::DEN_W'(radius_reg);
                rem_next  = cod_pkg::UNIT_W'(num);
                step_next = '0;
                quo_next  = '0;
                if (num >= den_next)
                begin
                    quo_next   = (den_next == '0) ? '0 : '1;
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_DIVIDE;
                end
            end
            ST_DIVIDE:
            begin
                rem_next  = unit_rsp.ge ? unit_rsp.diff : unit_req.rem;
                quo_next  = {quo_reg[cod_pkg::INTEN_W-2:0], unit_rsp.ge};
                step_next = step_reg + 1'b1;
                if (step_reg == cod_pkg::STEP_W'(cod_pkg::FRAC_W - 1))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!ovalid_reg || result.ready)
                begin
                    ovalid_next = 1'b1;
                    odist_next  = dist_reg;
                    oint_next   = quo_reg;
                    ostat_next  = status_reg;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            count_reg  <= '0;
            radius_reg <= cod_pkg::RADIUS_W'(128);
            maxd_reg   <= cod_pkg::MAXD_W'(1280);
            v1_reg     <= 1'b0;
            v2_reg     <= 1'b0;
            ovalid_reg <= 1'b0;
            idx_reg    <= '0;
            px_reg     <= '0;
            py_reg     <= '0;
            sqx_reg    <= '0;
            sqy_reg    <= '0;
            best_reg   <= '0;
            any_reg    <= 1'b0;
            val_reg    <= '0;
            rem_reg    <= '0;
            root_reg   <= '0;
            step_reg   <= '0;
            den_reg    <= '0;
            dist_reg   <= '0;
            quo_reg    <= '0;
            status_reg <= 1'b0;
            odist_reg  <= '0;
            oint_reg   <= '0;
            ostat_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            radius_reg <= radius_next;
            maxd_reg   <= maxd_next;
            v1_reg     <= v1_next;
            v2_reg     <= v2_next;
            ovalid_reg <= ovalid_next;
            idx_reg    <= idx_next;
            px_reg     <= px_next;
            py_reg     <= py_next;
            sqx_reg    <= sqx_next;
            sqy_reg    <= sqy_next;
            best_reg   <= best_next;
            any_reg    <= any_next;
            val_reg    <= val_next;
            rem_reg    <= rem_next;
            root_reg   <= root_next;
            step_reg   <= step_next;
            den_reg    <= den_next;
            dist_reg   <= dist_next;
            quo_reg    <= quo_next;
            status_reg <= status_next;
            odist_reg  <= odist_next;
            oint_reg   <= oint_next;
            ostat_reg  <= ostat_next;
        end
    end

endmodule
